[rtl/core/rau_pkg.sv]
// Rational arithmetic unit: shared types and codes.
// Command and status words between controller and datapath; no dependencies.
package rau_pkg;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_MUL = 2'd2;
    localparam logic [1:0] FUNC_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic [1:0] MUL_P = 2'd0;
    localparam logic [1:0] MUL_Q = 2'd1;
    localparam logic [1:0] MUL_D = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_idx;
        logic       sum;
        logic       chk;
        logic       gcd_step;
        logic       div_load;
        logic       div_sel;
        logic       div_step;
        logic       div_store;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic err;
        logic zero;
        logic gcd_done;
        logic div_last;
    } sts_t;

endpackage

[rtl/core/rau_datapath.sv]
// Rational arithmetic unit datapath: shared multiplier, binary gcd, serial divider.
// Depends on rau_pkg.
module rau_datapath #(
    parameter int WORD_BITS = 32
) (
    input  logic               aclk,
    input  rau_pkg::cmd_t      cmd,
    output rau_pkg::sts_t      sts,
    input  logic [1:0]         s_func,
    input  logic [31:0]        s_num_a,
    input  logic [31:0]        s_den_a,
    input  logic [31:0]        s_num_b,
    input  logic [31:0]        s_den_b,
    output logic [31:0]        m_num_out,
    output logic [30:0]        m_den_out,
    output logic [1:0]         m_status
);
    localparam int W  = WORD_BITS;
    localparam int MW = 2 * WORD_BITS;
    localparam int CW = $clog2(MW);

    logic [1:0]    func_reg;
    logic [W-1:0]  na_reg, da_reg, nb_reg, db_reg;
    logic          sna_reg, sda_reg, snb_reg, sdb_reg;
    logic [MW-1:0] p_reg, q_reg, num_reg, den_reg;
    logic          snum_reg, sden_reg, err_reg, zero_reg;
    logic [MW-1:0] ga_reg, gb_reg, quo_reg, rem_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0]   num_out_reg;
    logic [30:0]   den_out_reg;
    logic [1:0]    status_reg;

    logic [W-1:0]  va, vda, vb, vdb, a_op, b_op;
    logic [MW-1:0] prod;
    logic          sp, sq, sden;
    logic [MW-1:0] sum_mag;
    logic          sum_sgn;
    logic [MW:0]   rem2;
    logic          qbit;
    logic [MW-1:0] half;
    logic          sres, ovf;
    logic [31:0]   num32;

    assign va  = s_num_a[W-1:0];
    assign vda = s_den_a[W-1:0];
    assign vb  = s_num_b[W-1:0];
    assign vdb = s_den_b[W-1:0];

    always_comb begin
        unique case (cmd.mul_idx)
            rau_pkg::MUL_P: begin
                a_op = na_reg;
                b_op = (func_reg == rau_pkg::FUNC_MUL) ? nb_reg : db_reg;
            end
            rau_pkg::MUL_Q: begin
                a_op = nb_reg;
                b_op = da_reg;
            end
            default: begin
                a_op = da_reg;
                b_op = (func_reg == rau_pkg::FUNC_DIV) ? nb_reg : db_reg;
            end
        endcase
    end

    assign prod = MW'(a_op) * MW'(b_op);

    assign sp   = (func_reg == rau_pkg::FUNC_MUL) ? (sna_reg ^ snb_reg) : (sna_reg ^ sdb_reg);
    assign sq   = snb_reg ^ sda_reg ^ (func_reg == rau_pkg::FUNC_SUB);
    assign sden = (func_reg == rau_pkg::FUNC_DIV) ? (sda_reg ^ snb_reg) : (sda_reg ^ sdb_reg);

    always_comb begin
        if (func_reg == rau_pkg::FUNC_MUL || func_reg == rau_pkg::FUNC_DIV) begin
            sum_mag = p_reg;
            sum_sgn = sp;
        end else if (sp == sq) begin
            sum_mag = p_reg + q_reg;
            sum_sgn = sp;
        end else if (p_reg >= q_reg) begin
            sum_mag = p_reg - q_reg;
            sum_sgn = sp;
        end else begin
            sum_mag = q_reg - p_reg;
            sum_sgn = sq;
        end
    end

    assign rem2 = {rem_reg, quo_reg[MW-1]};
    assign qbit = (rem2 >= {1'b0, ga_reg});

    assign sts.err      = (da_reg == '0) || (db_reg == '0) || (den_reg == '0);
    assign sts.zero     = (num_reg == '0);
    assign sts.gcd_done = (ga_reg == gb_reg);
    assign sts.div_last = (cnt_reg == CW'(MW - 1));

    assign half  = MW'(1) << (W - 1);
    assign sres  = snum_reg ^ sden_reg;
    assign ovf   = (den_reg > half - MW'(1)) || (num_reg > half) || (!sres && num_reg == half);
    assign num32 = 32'(num_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_func;
            sna_reg  <= va[W-1];
            sda_reg  <= vda[W-1];
            snb_reg  <= vb[W-1];
            sdb_reg  <= vdb[W-1];
            na_reg   <= va[W-1]  ? -va  : va;
            da_reg   <= vda[W-1] ? -vda : vda;
            nb_reg   <= vb[W-1]  ? -vb  : vb;
            db_reg   <= vdb[W-1] ? -vdb : vdb;
        end
        if (cmd.mul_en) begin
            unique case (cmd.mul_idx)
                rau_pkg::MUL_P: p_reg   <= prod;
                rau_pkg::MUL_Q: q_reg   <= prod;
                default:        den_reg <= prod;
            endcase
        end
        if (cmd.sum) begin
            num_reg  <= sum_mag;
            snum_reg <= sum_sgn;
            sden_reg <= sden;
        end
        if (cmd.chk) begin
            err_reg  <= sts.err;
            zero_reg <= sts.zero;
            ga_reg   <= num_reg;
            gb_reg   <= den_reg;
        end
        if (cmd.gcd_step && ga_reg != gb_reg) begin
            if (!ga_reg[0] && !gb_reg[0]) begin
                ga_reg  <= ga_reg >> 1;
                gb_reg  <= gb_reg >> 1;
                num_reg <= num_reg >> 1;
                den_reg <= den_reg >> 1;
            end else if (!ga_reg[0]) begin
                ga_reg <= ga_reg >> 1;
            end else if (!gb_reg[0]) begin
                gb_reg <= gb_reg >> 1;
            end else if (ga_reg > gb_reg) begin
                ga_reg <= (ga_reg - gb_reg) >> 1;
            end else begin
                gb_reg <= (gb_reg - ga_reg) >> 1;
            end
        end
        if (cmd.div_load) begin
            quo_reg <= cmd.div_sel ? den_reg : num_reg;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= qbit ? MW'(rem2 - {1'b0, ga_reg}) : rem2[MW-1:0];
            quo_reg <= {quo_reg[MW-2:0], qbit};
            cnt_reg <= cnt_reg + CW'(1);
        end
        if (cmd.div_store) begin
            if (cmd.div_sel) begin
                den_reg <= quo_reg;
            end else begin
                num_reg <= quo_reg;
            end
        end
        if (cmd.out_load) begin
            if (err_reg) begin
                num_out_reg <= '0;
                den_out_reg <= '0;
                status_reg  <= rau_pkg::ST_ZDEN;
            end else if (zero_reg) begin
                num_out_reg <= '0;
                den_out_reg <= 31'd1;
                status_reg  <= rau_pkg::ST_OK;
            end else if (ovf) begin
                num_out_reg <= '0;
                den_out_reg <= '0;
                status_reg  <= rau_pkg::ST_OVF;
            end else begin
                num_out_reg <= sres ? -num32 : num32;
                den_out_reg <= 31'(den_reg);
                status_reg  <= rau_pkg::ST_OK;
            end
        end
    end

    assign m_num_out = num_out_reg;
    assign m_den_out = den_out_reg;
    assign m_status  = status_reg;

endmodule

[rtl/core/rau_ctrl.sv]
// Rational arithmetic unit controller: sequences the datapath, owns the handshakes.
// Depends on rau_pkg.
module rau_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  rau_pkg::sts_t sts,
    output rau_pkg::cmd_t cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_SUM, S_CHK, S_GCD,
        S_DLN, S_DVN, S_SN, S_DLD, S_DVD, S_SD, S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                cmd.load = s_valid;
                if (s_valid) state_next = S_MUL0;
            end
            S_MUL0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_idx = rau_pkg::MUL_P;
                state_next  = S_MUL1;
            end
            S_MUL1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_idx = rau_pkg::MUL_Q;
                state_next  = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_idx = rau_pkg::MUL_D;
                state_next  = S_SUM;
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                cmd.chk    = 1'b1;
                state_next = (sts.err || sts.zero) ? S_FIN : S_GCD;
            end
            S_GCD: begin
                cmd.gcd_step = 1'b1;
                if (sts.gcd_done) state_next = S_DLN;
            end
            S_DLN: begin
                cmd.div_load = 1'b1;
                state_next   = S_DVN;
            end
            S_DVN: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) state_next = S_SN;
            end
            S_SN: begin
                cmd.div_store = 1'b1;
                state_next    = S_DLD;
            end
            S_DLD: begin
                cmd.div_load = 1'b1;
                cmd.div_sel  = 1'b1;
                state_next   = S_DVD;
            end
            S_DVD: begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = 1'b1;
                if (sts.div_last) state_next = S_SD;
            end
            S_SD: begin
                cmd.div_store = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = S_FIN;
            end
            S_FIN: begin
                cmd.out_load = !m_valid_reg || m_ready;
                if (cmd.out_load) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[rtl/core/rational_arithmetic_unit.sv]
// Rational arithmetic unit top level: fraction add/sub/mul/div with gcd reduction.
// Depends on rau_pkg, rau_ctrl, rau_datapath.
//
//  channel  | handshake         | words
//  ---------+-------------------+---------------------------------------------
//  input    | s_valid / s_ready | s_func, s_num_a, s_den_a, s_num_b, s_den_b
//  result   | m_valid / m_ready | m_num_out, m_den_out, m_status
//
// One word at a time: three products on the shared multiplier, a sum and the checks,
// then a binary gcd and two serial divisions by it, numerator first, then denominator.
// Zero and error cases skip gcd and the divisions.
// aresetn is synchronous; it clears the controller and the result valid.
// A held result does not block the next input; a second finished word waits
// in the controller until the result register frees.
module rational_arithmetic_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [31:0] s_num_a,
    input  logic [31:0] s_den_a,
    input  logic [31:0] s_num_b,
    input  logic [31:0] s_den_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_num_out,
    output logic [30:0] m_den_out,
    output logic [1:0]  m_status
);
    rau_pkg::cmd_t cmd;
    rau_pkg::sts_t sts;

    rau_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rau_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .aclk      (aclk),
        .cmd       (cmd),
        .sts       (sts),
        .s_func    (s_func),
        .s_num_a   (s_num_a),
        .s_den_a   (s_den_a),
        .s_num_b   (s_num_b),
        .s_den_b   (s_den_b),
        .m_num_out (m_num_out),
        .m_den_out (m_den_out),
        .m_status  (m_status)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    a_ok_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == rau_pkg::ST_OK |-> m_den_out != '0)
        else $error("ok result with zero denominator");

    a_err_num_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != rau_pkg::ST_OK |-> m_num_out == '0 && m_den_out == '0)
        else $error("error result with nonzero fields");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == rau_pkg::ST_OK || m_status == rau_pkg::ST_ZDEN ||
                    m_status == rau_pkg::ST_OVF)
        else $error("undefined status");

endmodule

[test/tb_rational_arithmetic_unit.sv]
// Testbench for rational_arithmetic_unit: fraction add/sub/mul/div with gcd reduction.
// Predicts each result word in-line and checks it in order; depends on rau_pkg and the RTL.
module tb_rational_arithmetic_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 3000000;

    typedef struct {
        logic [31:0] num;
        logic [30:0] den;
        logic [1:0]  st;
    } frac_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_func = rau_pkg::FUNC_ADD;
    logic [31:0] s_num_a = 0, s_den_a = 0, s_num_b = 0, s_den_b = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [31:0] m_num_out;
    logic [30:0] m_den_out;
    logic [1:0]  m_status;

    frac_t expected_q[$];
    int    errors = 0;
    int    words_sent = 0;
    int    words_seen = 0;
    int    cycles = 0;
    int    send_idle = 0;
    int    recv_idle = 0;

    rational_arithmetic_unit dut (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [63:0] mag(input logic [31:0] v);
        logic [31:0] n;
        n = -v;
        return v[31] ? {32'b0, n} : {32'b0, v};
    endfunction

    function automatic frac_t reduce_frac(input logic [1:0] f, input logic [31:0] a_n,
                                          input logic [31:0] a_d, input logic [31:0] b_n,
                                          input logic [31:0] b_d);
        frac_t r;
        logic [63:0] na, da, nb, db, p, q, mn, md, x, y, t;
        logic sp, sq, sn, sd;
        na = mag(a_n); da = mag(a_d); nb = mag(b_n); db = mag(b_d);
        r.num = 0; r.den = 0; r.st = rau_pkg::ST_OK;
        sn = 0;
        md = da * db;
        sd = a_d[31] ^ b_d[31];
        case (f)
            rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB: begin
                p = na * db; q = nb * da;
                sp = a_n[31] ^ b_d[31];
                sq = (b_n[31] ^ a_d[31]) ^ (f == rau_pkg::FUNC_SUB);
                if (sp == sq) begin
                    mn = p + q; sn = sp;
                end else if (p >= q) begin
                    mn = p - q; sn = sp;
                end else begin
                    mn = q - p; sn = sq;
                end
            end
            rau_pkg::FUNC_MUL: begin
                mn = na * nb; sn = a_n[31] ^ b_n[31];
            end
            default: begin
                mn = na * db; sn = a_n[31] ^ b_d[31];
                md = da * nb; sd = a_d[31] ^ b_n[31];
            end
        endcase
        if (da == 0 || db == 0 || md == 0) begin
            r.st = rau_pkg::ST_ZDEN;
            return r;
        end
        x = md; y = mn;
        while (y != 0) begin
            t = x % y; x = y; y = t;
        end
        mn = mn / x; md = md / x;
        if (mn == 0) begin
            md = 1; sn = 0;
        end else begin
            sn = sn ^ sd;
        end
        if (md > 64'h7fff_ffff || mn > 64'h8000_0000 || (!sn && mn == 64'h8000_0000)) begin
            r.st = rau_pkg::ST_OVF;
            return r;
        end
        r.num = sn ? 32'(-mn) : mn[31:0];
        r.den = md[30:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch word %0d %s: got %h want %h", words_seen, what, got, want);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            frac_t e;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word", m_num_out, 0);
            end else begin
                e = expected_q.pop_front();
                if (m_num_out !== e.num) report_mismatch("num", m_num_out, e.num);
                if (m_den_out !== e.den) report_mismatch("den", 32'(m_den_out), 32'(e.den));
                if (m_status !== e.st) report_mismatch("status", 32'(m_status), 32'(e.st));
            end
            words_seen++;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_word(input logic [1:0] f, input logic [31:0] a_n,
                             input logic [31:0] a_d, input logic [31:0] b_n,
                             input logic [31:0] b_d);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1; s_func <= f;
        s_num_a <= a_n; s_den_a <= a_d; s_num_b <= b_n; s_den_b <= b_d;
        expected_q.push_back(reduce_frac(f, a_n, a_d, b_n, b_d));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(40)) - 20);
            2: return 32'($signed($urandom_range(2000)) - 1000);
            3: return {$urandom_range(1) ? 16'hffff : 16'h0, 16'($urandom)};
            4: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    default: return 0;
                endcase
            end
            default: return 32'($urandom_range(12)) * 32'($urandom_range(12));
        endcase
    endfunction

    task automatic test_extremes();
        logic [31:0] ext[6] = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0, 1, 32'h5555_aaaa};
        for (int f = 0; f < 4; f++) begin
            send_word(2'(f), 3, 4, 5, 6);
            send_word(2'(f), ext[f], ext[(f+1)%6], ext[(f+2)%6], ext[(f+3)%6]);
            send_word(2'(f), 32'h8000_0000, 1, 32'h8000_0000, 1);
            send_word(2'(f), 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff);
        end
        send_word(rau_pkg::FUNC_DIV, 1, 2, 0, 3);
        send_word(rau_pkg::FUNC_ADD, 1, 0, 1, 2);
        send_word(rau_pkg::FUNC_MUL, 0, 5, 7, 9);
        send_word(rau_pkg::FUNC_SUB, 2, 3, 2, 3);
        send_word(rau_pkg::FUNC_MUL, 32'h8000_0000, 1, 32'hffff_ffff, 1);
        send_word(rau_pkg::FUNC_DIV, 32'h8000_0000, 1, 1, 32'hffff_ffff);
        send_word(rau_pkg::FUNC_MUL, 1, 32'hffff_fffd, 1, 1);
    endtask

    task automatic test_random(input int n, input int s_idle, input int r_idle);
        send_idle = s_idle;
        recv_idle = r_idle;
        repeat (n) send_word(2'($urandom_range(3)), rand_operand(), rand_operand(),
                             rand_operand(), rand_operand());
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_extremes();
        test_random(500, 18, 82);
        test_random(500, 82, 18);
        test_random(500, 0, 0);
        s_valid <= 0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("sent %0d words over all four operations, checked %0d results",
                 words_sent, words_seen);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
